/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL. They expect clk and arst_n in
// the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define KHCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define KHCT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* design/khct_pkg.sv */
// ---------------------------------------------------------------------------
// khct_pkg
// Types, constants and codes for the keyed hit counter table.
// ---------------------------------------------------------------------------
package khct_pkg;

	localparam int unsigned CAPACITY = 64;
	localparam int unsigned IDX_W    = $clog2(CAPACITY);
	localparam int unsigned OCC_W    = $clog2(CAPACITY + 1);

	localparam int unsigned OP_W     = 3;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned EIDX_W   = 6;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OCCF_W   = 7;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 3'd0,
		OP_DELETE = 3'd1,
		OP_HIT    = 3'd2,
		OP_QUERY  = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE,
		S_RDWAIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} entry_t;

	// One read port and one write port of the entry store.
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [KEY_W-1:0]    key_out;
		logic [CNT_W-1:0]    count_out;
	} result_t;

	// Saturating counter increment.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (&c) ? c : c + CNT_W'(1);
	endfunction

endpackage

/* design/khct_if.sv */
// ---------------------------------------------------------------------------
// khct request and response channels
// Valid/ready channels carrying one table request and one table response.
// ---------------------------------------------------------------------------
interface khct_req_if;
	logic                            valid;
	logic                            ready;
	logic [khct_pkg::OP_W-1:0]       op;
	logic [khct_pkg::KEY_W-1:0]      key;
	logic [khct_pkg::EIDX_W-1:0]     entry_index;

	modport source (output valid, op, key, entry_index, input ready);
	modport sink   (input valid, op, key, entry_index, output ready);
endinterface

interface khct_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [khct_pkg::STATUS_W-1:0]   status;
	logic                            found;
	logic [khct_pkg::KEY_W-1:0]      key_out;
	logic [khct_pkg::CNT_W-1:0]      count_out;
	logic [khct_pkg::OCCF_W-1:0]     occupancy;

	modport source (output valid, status, found, key_out, count_out, occupancy, input ready);
	modport sink   (input valid, status, found, key_out, count_out, occupancy, output ready);
endinterface

/* design/khct_store.sv */
// ---------------------------------------------------------------------------
// khct_store
// Entry memory: key and counter side by side, one write and one read port,
// registered read data.
// ---------------------------------------------------------------------------
module khct_store (
	input  logic               clk,
	input  khct_pkg::mem_cmd_t cmd,
	output khct_pkg::entry_t   rd_data
);

	khct_pkg::entry_t mem_q [khct_pkg::CAPACITY];
	khct_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[cmd.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/keyed_hit_counter_table.sv */
// ---------------------------------------------------------------------------
// keyed_hit_counter_table
// Fixed-capacity table of keys with saturating hit counters.
// ---------------------------------------------------------------------------
// The table holds up to CAPACITY (64) entries packed at positions 0 to
// occupancy-1 in a single-port-read, single-port-write memory, and handles
// one request at a time. Add, the unused op codes and every request that is
// answered without touching the memory (a full table, an empty table, a read
// beyond the occupancy) go from idle straight to the response state; a read
// passes through the read-wait state first. Delete, hit and query scan the
// entries from position 0, one memory read per cycle, until the key matches
// or the last position has been compared; a delete that must move the last
// entry into the hole also passes through the move state. The response state
// hands the result on once the response register is empty or being taken,
// so a stalled consumer keeps the table waiting in that state.
// A new request is taken once the previous one has been handed to the
// response register, even while that response still waits for the consumer.
// Duplicate keys are allowed; delete and hit act on the first match. Entry
// contents have no reset, as only positions below the occupancy are ever
// read.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_hit_counter_table (
	input  logic              clk,
	input  logic              arst_n,
	khct_req_if.sink          req,
	khct_rsp_if.source        rsp
);

	localparam int unsigned IDX_W = khct_pkg::IDX_W;
	localparam int unsigned OCC_W = khct_pkg::OCC_W;

	khct_pkg::state_t  state_q, state_d;
	khct_pkg::mem_cmd_t cmd;
	khct_pkg::entry_t  rd_data;

	// Request held for the duration of the operation.
	logic [khct_pkg::OP_W-1:0]  op_q;
	logic [khct_pkg::KEY_W-1:0] key_q;

	// Entry count and scan position.
	logic [OCC_W-1:0] total_q, total_d;
	logic [IDX_W-1:0] cmp_addr_q, cmp_addr_d;
	logic [OCC_W-1:0] next_pos;
	logic [OCC_W-1:0] last_pos;

	// Result being built, and the response register facing the consumer.
	khct_pkg::result_t res_q, res_d;
	khct_pkg::result_t out_q;
	logic [khct_pkg::OCCF_W-1:0] out_occ_q;
	logic out_valid_q;
	logic out_load;
	logic accept;

	khct_store u_store (
		.clk     (clk),
		.cmd     (cmd),
		.rd_data (rd_data)
	);

	assign req.ready = (state_q == khct_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign next_pos  = OCC_W'(cmp_addr_q) + OCC_W'(1);
	assign last_pos  = total_q - OCC_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= khct_pkg::S_IDLE;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.op;
			key_q <= req.key;
		end
		cmp_addr_q <= cmp_addr_d;
		res_q      <= res_d;
		if (out_load) begin
			out_q     <= res_q;
			out_occ_q <= khct_pkg::OCCF_W'(total_q);
		end
	end

	// Sequencer: each request starts in the idle state, optionally walks the
	// memory, and finishes by handing its result to the response register.
	always_comb begin
		state_d    = state_q;
		total_d    = total_q;
		cmp_addr_d = cmp_addr_q;
		res_d      = res_q;
		cmd        = '0;
		out_load   = 1'b0;

		unique case (state_q)
			khct_pkg::S_IDLE: begin
				if (req.valid) begin
					res_d   = '0;
					state_d = khct_pkg::S_RESP;
					case (req.op)
						khct_pkg::OP_ADD: begin
							if (total_q < OCC_W'(khct_pkg::CAPACITY)) begin
								cmd.wr_en         = 1'b1;
								cmd.wr_addr       = IDX_W'(total_q);
								cmd.wr_data.key   = req.key;
								cmd.wr_data.count = '0;
								total_d           = total_q + OCC_W'(1);
							end else begin
								res_d.status = khct_pkg::ST_FULL;
							end
						end
						khct_pkg::OP_DELETE, khct_pkg::OP_HIT, khct_pkg::OP_QUERY: begin
							if (total_q == '0) begin
								res_d.status = khct_pkg::ST_NOT_FOUND;
							end else begin
								cmd.rd_en   = 1'b1;
								cmd.rd_addr = '0;
								cmp_addr_d  = '0;
								state_d     = khct_pkg::S_SCAN;
							end
						end
						khct_pkg::OP_READ: begin
							if (32'(req.entry_index) < 32'(total_q)) begin
								cmd.rd_en   = 1'b1;
								cmd.rd_addr = IDX_W'(req.entry_index);
								state_d     = khct_pkg::S_RDWAIT;
							end else begin
								res_d.status = khct_pkg::ST_BAD_INDEX;
							end
						end
						default: begin
						end
					endcase
				end
			end

			khct_pkg::S_SCAN: begin
				// rd_data holds the entry at cmp_addr_q, read last cycle.
				if (rd_data.key == key_q) begin
					state_d = khct_pkg::S_RESP;
					case (op_q)
						khct_pkg::OP_QUERY: begin
							res_d.found = 1'b1;
						end
						khct_pkg::OP_HIT: begin
							cmd.wr_en         = 1'b1;
							cmd.wr_addr       = cmp_addr_q;
							cmd.wr_data.key   = rd_data.key;
							cmd.wr_data.count = khct_pkg::sat_inc(rd_data.count);
							res_d.found       = 1'b1;
							res_d.count_out   = khct_pkg::sat_inc(rd_data.count);
						end
						khct_pkg::OP_DELETE: begin
							if (OCC_W'(cmp_addr_q) == last_pos) begin
								total_d = last_pos;
							end else begin
								// Fetch the last entry to fill the hole.
								cmd.rd_en   = 1'b1;
								cmd.rd_addr = IDX_W'(last_pos);
								state_d     = khct_pkg::S_MOVE;
							end
						end
						default: begin
						end
					endcase
				end else if (next_pos < total_q) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = IDX_W'(next_pos);
					cmp_addr_d  = IDX_W'(next_pos);
				end else begin
					res_d.status = khct_pkg::ST_NOT_FOUND;
					state_d      = khct_pkg::S_RESP;
				end
			end

			khct_pkg::S_MOVE: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = cmp_addr_q;
				cmd.wr_data = rd_data;
				total_d     = last_pos;
				state_d     = khct_pkg::S_RESP;
			end

			khct_pkg::S_RDWAIT: begin
				res_d.key_out   = rd_data.key;
				res_d.count_out = rd_data.count;
				state_d         = khct_pkg::S_RESP;
			end

			khct_pkg::S_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = khct_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = khct_pkg::S_IDLE;
			end
		endcase
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_q.status;
	assign rsp.found     = out_q.found;
	assign rsp.key_out   = out_q.key_out;
	assign rsp.count_out = out_q.count_out;
	assign rsp.occupancy = out_occ_q;

	// The occupancy can never pass the capacity.
	`KHCT_ASSERT(a_total_bound, total_q <= OCC_W'(khct_pkg::CAPACITY), "occupancy above capacity")
	// The memory is never read and written in the same cycle, so no forwarding is needed.
	`KHCT_NEVER(a_no_rw_overlap, cmd.rd_en && cmd.wr_en, "memory read and write collide")
	// The occupancy moves by at most one entry per cycle.
	`KHCT_ASSERT(a_total_step, (total_q != $past(total_q)) |-> (total_q == $past(total_q) + OCC_W'(1) || total_q == $past(total_q) - OCC_W'(1)), "occupancy jumped")
	// A scan never compares a position beyond the occupancy.
	`KHCT_ASSERT(a_scan_in_range, (state_q == khct_pkg::S_SCAN) |-> (OCC_W'(cmp_addr_q) < total_q), "scan beyond occupancy")
	// An accepted request always leaves the idle state.
	`KHCT_ASSERT(a_accept_busy, accept |=> (state_q != khct_pkg::S_IDLE), "request accepted but not started")

endmodule
